// ===== hdl/ihtab_pkg.sv =====
// ----------------------------------------------------------------------------
// ihtab_pkg
// Shared types and constants for the id to handle table.
// ----------------------------------------------------------------------------
package ihtab_pkg;

	localparam int TABLE_ENTRIES_DEF = 64;

	localparam int IDENT_W = 64;
	localparam int HANDLE_W = 32;
	localparam int KEY_W = 24;
	localparam int COUNT_OUT_W = 7;
	localparam int ENTRY_W = KEY_W + IDENT_W;

	localparam logic [7:0] HANDLE_TOP = 8'd10;
	localparam logic [7:0] BYTE_MASK = 8'hFF;

	localparam logic REQ_REGISTER = 1'b0;
	localparam logic REQ_LOOKUP = 1'b1;

	typedef struct packed {
		logic req_type;
		logic [IDENT_W-1:0] ident;
		logic [HANDLE_W-1:0] lookup_handle;
	} req_t;

	typedef struct packed {
		logic [HANDLE_W-1:0] derived_handle;
		logic [IDENT_W-1:0] found_ident;
		logic found;
		logic collision;
		logic table_full;
		logic [COUNT_OUT_W-1:0] entry_count;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_SCAN,
		ST_INSERT,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load_req;
		logic scan;
		logic insert;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic searchable;
		logic empty;
		logic hit;
		logic last_miss;
		logic out_free;
	} status_t;

	// handle bytes: 10, id[23:16], id[15:8], low byte with 0 and 0xFF mapped to 1
	function automatic logic [HANDLE_W-1:0] derive_handle(input logic [IDENT_W-1:0] id);
		logic [7:0] lo;
		lo = id[7:0];
		if (lo == 8'd0 || lo == BYTE_MASK) begin
			lo = 8'd1;
		end
		if (id == '0) begin
			return '0;
		end
		return {HANDLE_TOP, id[23:16], id[15:8], lo};
	endfunction

endpackage

// ===== hdl/ihtab_ram.sv =====
// ----------------------------------------------------------------------------
// ihtab_ram
// Generic simple dual port RAM, one write port, registered read port.
// ----------------------------------------------------------------------------
module ihtab_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                   clk,
	input  logic                   wr_en,
	input  logic [AW-1:0]          wr_addr,
	input  logic [WIDTH-1:0]       wr_data,
	input  logic                   rd_en,
	input  logic [AW-1:0]          rd_addr,
	output logic [WIDTH-1:0]       rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ===== hdl/ihtab_ctrl.sv =====
// ----------------------------------------------------------------------------
// ihtab_ctrl
// Sequencer: takes a request, runs the table scan, the insert and the result load.
// ----------------------------------------------------------------------------
module ihtab_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  ihtab_pkg::status_t st,
	output ihtab_pkg::cmd_t    cmd
);
	ihtab_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ihtab_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ihtab_pkg::ST_IDLE: begin
				if (req_valid) begin
					state_d = ihtab_pkg::ST_CHECK;
				end
			end
			ihtab_pkg::ST_CHECK: begin
				if (!st.searchable) begin
					state_d = ihtab_pkg::ST_DONE;
				end else if (st.empty) begin
					state_d = ihtab_pkg::ST_INSERT;
				end else begin
					state_d = ihtab_pkg::ST_SCAN;
				end
			end
			ihtab_pkg::ST_SCAN: begin
				if (st.hit) begin
					state_d = ihtab_pkg::ST_DONE;
				end else if (st.last_miss) begin
					state_d = ihtab_pkg::ST_INSERT;
				end
			end
			ihtab_pkg::ST_INSERT: begin
				state_d = ihtab_pkg::ST_DONE;
			end
			ihtab_pkg::ST_DONE: begin
				if (st.out_free) begin
					state_d = ihtab_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = ihtab_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd = '0;
		req_stall = 1'b1;
		case (state_q)
			ihtab_pkg::ST_IDLE: begin
				req_stall = 1'b0;
				cmd.load_req = req_valid;
			end
			ihtab_pkg::ST_SCAN: begin
				cmd.scan = 1'b1;
			end
			ihtab_pkg::ST_INSERT: begin
				cmd.insert = 1'b1;
			end
			ihtab_pkg::ST_DONE: begin
				cmd.load_out = st.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	// only one datapath command at a time
	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cmd))
		else $error("ihtab_ctrl: more than one command");

	// a scan only starts on a non-empty table with a searchable key
	a_scan_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ihtab_pkg::ST_CHECK && state_d == ihtab_pkg::ST_SCAN)
			|-> (st.searchable && !st.empty))
		else $error("ihtab_ctrl: scan started without need");

	// a request is only taken when the result of the previous one was loaded
	a_load_then_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_req |-> $past(state_q) == ihtab_pkg::ST_DONE || $past(state_q) == ihtab_pkg::ST_IDLE)
		else $error("ihtab_ctrl: request taken mid-item");

endmodule

// ===== hdl/ihtab_dp.sv =====
// ----------------------------------------------------------------------------
// ihtab_dp
// Datapath: request registers, entry store, scan pointer, fill count, result register.
// ----------------------------------------------------------------------------
module ihtab_dp #(
	parameter int TABLE_ENTRIES = ihtab_pkg::TABLE_ENTRIES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ihtab_pkg::req_t     req,
	input  ihtab_pkg::cmd_t     cmd,
	output ihtab_pkg::status_t  st,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output ihtab_pkg::rsp_t     rsp
);
	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(TABLE_ENTRIES);

	// request held for the item
	logic                               is_reg_q;
	logic                               srch_q;
	logic [ihtab_pkg::KEY_W-1:0]        key_q;
	logic [ihtab_pkg::HANDLE_W-1:0]     dh_q;
	logic [ihtab_pkg::IDENT_W-1:0]      ident_q;

	logic [CNT_W-1:0]                   count_q;
	logic [CNT_W-1:0]                   rd_idx_q;
	logic                               rd_vld_s1;
	logic                               last_s1;
	logic                               hit_q;
	logic                               full_q;
	logic [ihtab_pkg::IDENT_W-1:0]      fid_q;

	logic                               rsp_valid_q;
	ihtab_pkg::rsp_t                    rsp_q;

	logic [ihtab_pkg::HANDLE_W-1:0]     dh_new;
	logic                               issue;
	logic                               match;
	logic                               wr_en;
	logic                               table_at_max;
	logic [ihtab_pkg::ENTRY_W-1:0]      rd_data;
	logic [ihtab_pkg::KEY_W-1:0]        rd_key;
	logic [ihtab_pkg::IDENT_W-1:0]      rd_ident;

	assign dh_new = ihtab_pkg::derive_handle(req.ident);
	assign table_at_max = (count_q == CNT_MAX);
	assign issue = cmd.scan && (rd_idx_q < count_q);
	assign rd_key = rd_data[ihtab_pkg::ENTRY_W-1:ihtab_pkg::IDENT_W];
	assign rd_ident = rd_data[ihtab_pkg::IDENT_W-1:0];
	assign match = rd_vld_s1 && (rd_key == key_q);
	assign wr_en = cmd.insert && is_reg_q && !table_at_max;

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			is_reg_q <= (req.req_type == ihtab_pkg::REQ_REGISTER);
			ident_q <= req.ident;
			if (req.req_type == ihtab_pkg::REQ_REGISTER) begin
				dh_q <= dh_new;
				key_q <= dh_new[ihtab_pkg::KEY_W-1:0];
				srch_q <= (req.ident != '0);
			end else begin
				dh_q <= '0;
				key_q <= req.lookup_handle[ihtab_pkg::KEY_W-1:0];
				srch_q <= (req.lookup_handle[31:24] == ihtab_pkg::HANDLE_TOP);
			end
		end
	end

	ihtab_ram #(
		.WIDTH (ihtab_pkg::ENTRY_W),
		.DEPTH (TABLE_ENTRIES)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (count_q[IDX_W-1:0]),
		.wr_data ({key_q, ident_q}),
		.rd_en   (issue),
		.rd_addr (rd_idx_q[IDX_W-1:0]),
		.rd_data (rd_data)
	);

	// entries fill from the bottom and are never freed, so valid == index below count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			rd_idx_q <= '0;
			rd_vld_s1 <= 1'b0;
			last_s1 <= 1'b0;
			hit_q <= 1'b0;
			full_q <= 1'b0;
			fid_q <= '0;
		end else begin
			if (cmd.load_req) begin
				rd_idx_q <= '0;
				rd_vld_s1 <= 1'b0;
				last_s1 <= 1'b0;
				hit_q <= 1'b0;
				full_q <= 1'b0;
				fid_q <= '0;
			end else if (cmd.scan) begin
				rd_vld_s1 <= issue;
				last_s1 <= issue && ((rd_idx_q + CNT_W'(1)) == count_q);
				if (issue) begin
					rd_idx_q <= rd_idx_q + CNT_W'(1);
				end
				if (match) begin
					hit_q <= 1'b1;
					fid_q <= rd_ident;
				end
			end
			if (cmd.insert && is_reg_q) begin
				full_q <= table_at_max;
			end
			if (wr_en) begin
				count_q <= count_q + CNT_W'(1);
			end
		end
	end

	assign st.searchable = srch_q;
	assign st.empty = (count_q == '0);
	assign st.hit = match;
	assign st.last_miss = rd_vld_s1 && last_s1 && !match;
	assign st.out_free = !rsp_valid_q || !rsp_stall;

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			rsp_q.derived_handle <= dh_q;
			rsp_q.found_ident <= fid_q;
			rsp_q.found <= hit_q;
			rsp_q.collision <= is_reg_q && hit_q && (fid_q != ident_q);
			rsp_q.table_full <= full_q;
			rsp_q.entry_count <= ihtab_pkg::COUNT_OUT_W'(count_q);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_MAX)
		else $error("ihtab_dp: entry count beyond table size");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != $past(count_q) |-> $past(wr_en) && count_q == $past(count_q) + CNT_W'(1))
		else $error("ihtab_dp: entry count moved without an insert");

	a_collision_found: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> (!rsp_q.collision || rsp_q.found) && !(rsp_q.table_full && rsp_q.found))
		else $error("ihtab_dp: inconsistent result flags");

endmodule

// ===== hdl/id_to_handle_table.sv =====
// A new item is taken only in the idle state, once the result of the previous one has
// been loaded; the scan reads one stored entry per cycle from a single registered-read
// memory port, so a full scan takes longer as the entry count grows.
// Reset: arst_n clears the fill count and control state; the table is empty at once,
// with no clearing pass, since entries fill from index 0 and are never freed.
// ----------------------------------------------------------------------------
// id_to_handle_table
// Maps 32-bit handles derived from 64-bit identifiers back to the identifiers.
// ----------------------------------------------------------------------------
module id_to_handle_table #(
	parameter int TABLE_ENTRIES = ihtab_pkg::TABLE_ENTRIES_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  ihtab_pkg::req_t req,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output ihtab_pkg::rsp_t rsp
);
	ihtab_pkg::cmd_t    cmd;
	ihtab_pkg::status_t st;

	ihtab_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.st        (st),
		.cmd       (cmd)
	);

	ihtab_dp #(
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.st        (st),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule
